[hdl/spc_pkg.sv]
// spc_pkg: shared types, codes and constants of the subleq processor core
// no dependencies; imported by spc_controller, spc_datapath and the top level

package spc_pkg;

  localparam int unsigned WORD_BITS         = 48;
  localparam int unsigned FIELD_BITS        = 16;
  localparam int unsigned STEP_BITS         = 32;
  localparam int unsigned OPCODE_BITS       = 3;
  localparam int unsigned CFG_INDEX_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS     = 32;
  localparam int unsigned DEFAULT_ADDR_BITS = 16;

  localparam logic [FIELD_BITS-1:0] START_ADDRESS_RESET = 16'd1;
  localparam logic [STEP_BITS-1:0]  STEP_LIMIT_RESET    = '0;
  localparam logic [STEP_BITS-1:0]  STEP_MAX            = '1;

  // opcodes of an input transaction
  localparam logic [OPCODE_BITS-1:0] OP_WRITE   = 3'd0;
  localparam logic [OPCODE_BITS-1:0] OP_READ    = 3'd1;
  localparam logic [OPCODE_BITS-1:0] OP_STEP    = 3'd2;
  localparam logic [OPCODE_BITS-1:0] OP_RUN     = 3'd3;
  localparam logic [OPCODE_BITS-1:0] OP_RESTART = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_LIMIT    = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_STORE,
    ST_DONE
  } state_t;

  // what the single memory port does in a cycle
  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_CLEAR,
    MEM_HOST_WRITE,
    MEM_HOST_READ,
    MEM_FETCH,
    MEM_LOAD_A,
    MEM_LOAD_B,
    MEM_STORE_B
  } mem_sel_t;

  typedef struct packed {
    mem_sel_t mem_sel;
    logic     item_start;
    logic     item_run;
    logic     item_step;
    logic     item_read;
    logic     pc_restart;
    logic     result_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic run_go;
  } status_t;

endpackage

[hdl/subleq_processor_core.sv]
// subleq_processor_core: top level of the subleq one-instruction computer
// depends on spc_pkg, spc_controller and spc_datapath
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    opcode, word_address, write_data
// out      output     out_valid / out_ready  read_data, program_counter, halted,
//                                            steps_done, limit_reached
// cfg      input      cfg_write (no wait)    cfg_index, cfg_data
//
// write, read, restart and unknown opcodes: registered result, loaded from the done state
// step and run: each instruction passes fetch, load a, load b and write-back
//   on the single memory port until a halt or the step limit; the result is then
//   loaded from the done state and the next transaction is taken back in idle
// reset: a clearing pass zeroes every memory word, no transaction
//   accepted meanwhile; configuration writes are taken as ever
// one transaction in work at a time; the next is accepted while a result
//   still waits in the output register, which holds under out_ready low

module subleq_processor_core #(
  parameter int unsigned ADDR_BITS = spc_pkg::DEFAULT_ADDR_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // input transactions
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [spc_pkg::OPCODE_BITS-1:0]     opcode,
  input  logic [spc_pkg::FIELD_BITS-1:0]      word_address,
  input  logic [spc_pkg::WORD_BITS-1:0]       write_data,
  // result transactions
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spc_pkg::WORD_BITS-1:0]       read_data,
  output logic [spc_pkg::FIELD_BITS-1:0]      program_counter,
  output logic                                halted,
  output logic [spc_pkg::STEP_BITS-1:0]       steps_done,
  output logic                                limit_reached,
  // configuration writes
  input  logic                                cfg_write,
  input  logic [spc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [spc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import spc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: clearing pass, opcode dispatch, four-phase step loop
  spc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // memory, pc, counters and the result register
  spc_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .word_address    (word_address),
    .write_data      (write_data),
    .read_data       (read_data),
    .program_counter (program_counter),
    .halted          (halted),
    .steps_done      (steps_done),
    .limit_reached   (limit_reached)
  );

endmodule

[hdl/spc_controller.sv]
// spc_controller: state machine sequencing transactions and subleq steps
// depends on spc_pkg; drives the command struct of spc_datapath

module spc_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [spc_pkg::OPCODE_BITS-1:0]     opcode,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  spc_pkg::status_t                    status,
  output spc_pkg::cmd_t                       cmd
);
  import spc_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_STEP || opcode == OP_RUN) state_next = ST_FETCH;
          else state_next = ST_DONE;
        end
      end
      ST_FETCH: begin
        if (status.run_go) state_next = ST_LOAD_A;
        else state_next = ST_DONE;
      end
      ST_LOAD_A: state_next = ST_LOAD_B;
      ST_LOAD_B: state_next = ST_STORE;
      ST_STORE:  state_next = ST_FETCH;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd         = '0;
    cmd.mem_sel = MEM_IDLE;
    unique case (state)
      ST_CLEAR: cmd.mem_sel = MEM_CLEAR;
      ST_IDLE: begin
        if (accept) begin
          cmd.item_start = 1'b1;
          unique case (opcode)
            OP_WRITE:   cmd.mem_sel = MEM_HOST_WRITE;
            OP_READ: begin
              cmd.mem_sel   = MEM_HOST_READ;
              cmd.item_read = 1'b1;
            end
            OP_STEP:    cmd.item_step  = 1'b1;
            OP_RUN:     cmd.item_run   = 1'b1;
            OP_RESTART: cmd.pc_restart = 1'b1;
            default:    cmd.mem_sel    = MEM_IDLE;
          endcase
        end
      end
      ST_FETCH: begin
        if (status.run_go) cmd.mem_sel = MEM_FETCH;
      end
      ST_LOAD_A: cmd.mem_sel = MEM_LOAD_A;
      ST_LOAD_B: cmd.mem_sel = MEM_LOAD_B;
      ST_STORE:  cmd.mem_sel = MEM_STORE_B;
      ST_DONE:   cmd.result_load = out_free;
      default:   cmd.mem_sel = MEM_IDLE;
    endcase
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("transaction accepted during memory clear");

  a_exec_enters_fetch: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_STEP || opcode == OP_RUN)) |=> (state == ST_FETCH))
    else $error("step or run did not start at fetch");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> out_free)
    else $error("result loaded over an untaken result");

  a_store_follows_load_b: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD_B) |=> (cmd.mem_sel == MEM_STORE_B))
    else $error("operand b load not followed by write-back");

endmodule

[hdl/spc_datapath.sv]
// spc_datapath: program memory, pc, step counter, config registers, result
// depends on spc_pkg; commanded by spc_controller

module spc_datapath #(
  parameter int unsigned ADDR_BITS = spc_pkg::DEFAULT_ADDR_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spc_pkg::cmd_t                       cmd,
  output spc_pkg::status_t                    status,
  input  logic                                cfg_write,
  input  logic [spc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [spc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [spc_pkg::FIELD_BITS-1:0]      word_address,
  input  logic [spc_pkg::WORD_BITS-1:0]       write_data,
  output logic [spc_pkg::WORD_BITS-1:0]       read_data,
  output logic [spc_pkg::FIELD_BITS-1:0]      program_counter,
  output logic                                halted,
  output logic [spc_pkg::STEP_BITS-1:0]       steps_done,
  output logic                                limit_reached
);
  import spc_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  // 16-bit address field reduced or widened to the memory address width
  function automatic logic [ADDR_BITS-1:0] to_addr(input logic [FIELD_BITS-1:0] f);
    logic [31:0] ext;
    ext = {16'b0, f};
    return ext[ADDR_BITS-1:0];
  endfunction

  localparam logic [ADDR_BITS-1:0] PC_RESET = to_addr(START_ADDRESS_RESET);

  logic [WORD_BITS-1:0]  mem [DEPTH];
  logic [WORD_BITS-1:0]  mem_rdata;
  logic [ADDR_BITS-1:0]  mem_addr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic                  mem_we;
  logic                  mem_re;

  logic [FIELD_BITS-1:0] start_address;
  logic [STEP_BITS-1:0]  step_limit;
  logic [ADDR_BITS-1:0]  pc;
  logic [ADDR_BITS-1:0]  pc_next;
  logic [ADDR_BITS-1:0]  clr_addr;
  logic [WORD_BITS-1:0]  ins;
  logic [WORD_BITS-1:0]  a_val;
  logic [WORD_BITS-1:0]  diff;
  logic                  take_jump;
  logic [STEP_BITS-1:0]  steps;
  logic [STEP_BITS-1:0]  lim;
  logic                  run_flag;
  logic                  read_flag;
  logic [31:0]           pc_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= START_ADDRESS_RESET;
      step_limit    <= STEP_LIMIT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_START_ADDRESS) start_address <= cfg_data[FIELD_BITS-1:0];
      if (cfg_index == CFG_STEP_LIMIT) step_limit <= cfg_data[STEP_BITS-1:0];
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = pc;
    mem_wdata = '0;
    unique case (cmd.mem_sel)
      MEM_IDLE: mem_addr = pc;
      MEM_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      MEM_HOST_WRITE: begin
        mem_we    = 1'b1;
        mem_addr  = to_addr(word_address);
        mem_wdata = write_data;
      end
      MEM_HOST_READ: begin
        mem_re   = 1'b1;
        mem_addr = to_addr(word_address);
      end
      MEM_FETCH: begin
        mem_re   = 1'b1;
        mem_addr = pc;
      end
      MEM_LOAD_A: begin
        mem_re   = 1'b1;
        mem_addr = to_addr(mem_rdata[47:32]);
      end
      MEM_LOAD_B: begin
        mem_re   = 1'b1;
        mem_addr = to_addr(ins[31:16]);
      end
      MEM_STORE_B: begin
        mem_we    = 1'b1;
        mem_addr  = to_addr(ins[31:16]);
        mem_wdata = diff;
      end
      default: mem_addr = pc;
    endcase
  end

  // single-port program memory, read data held while idle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.mem_sel == MEM_CLEAR) begin
      clr_addr <= clr_addr + ADDR_BITS'(1);
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.mem_sel == MEM_LOAD_A) ins <= mem_rdata;
    if (cmd.mem_sel == MEM_LOAD_B) a_val <= mem_rdata;
  end

  // mem[b] - mem[a] and the branch test on the result
  assign diff      = mem_rdata - a_val;
  assign take_jump = diff[WORD_BITS-1] || (diff == '0);
  assign pc_next   = take_jump ? to_addr(ins[15:0]) : pc + ADDR_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_RESET;
    end else if (cmd.pc_restart) begin
      pc <= to_addr(start_address);
    end else if (cmd.mem_sel == MEM_STORE_B) begin
      pc <= pc_next;
    end
  end

  // per-transaction step count and limit
  always_ff @(posedge clk) begin
    if (cmd.item_start) begin
      steps     <= '0;
      run_flag  <= cmd.item_run;
      read_flag <= cmd.item_read;
      if (cmd.item_run) lim <= (step_limit == '0) ? STEP_MAX : step_limit;
      else if (cmd.item_step) lim <= STEP_BITS'(1);
      else lim <= '0;
    end else if (cmd.mem_sel == MEM_STORE_B) begin
      steps <= steps + STEP_BITS'(1);
    end
  end

  assign status.clear_last = &clr_addr;
  assign status.run_go     = (pc != '0) && (steps != lim);

  assign pc_ext = {{(32 - ADDR_BITS){1'b0}}, pc};

  // result register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      read_data       <= read_flag ? mem_rdata : '0;
      program_counter <= pc_ext[FIELD_BITS-1:0];
      halted          <= (pc == '0);
      steps_done      <= steps;
      limit_reached   <= run_flag && (pc != '0);
    end
  end

  a_fetch_not_halted: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_sel == MEM_FETCH) |-> (pc != '0))
    else $error("instruction fetched while halted");

  a_store_counts_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_sel == MEM_STORE_B) |=> (steps == $past(steps) + STEP_BITS'(1)))
    else $error("write-back did not count a step");

  a_fetch_below_limit: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_sel == MEM_FETCH) |-> (steps != lim))
    else $error("fetch beyond step limit");

endmodule

[tb/subleq_processor_core_tb.sv]
// subleq_processor_core_tb: self-checking testbench of the subleq processor core
// depends on spc_pkg and subleq_processor_core; a built-in predictor supplies the
// expected result of every input transaction

module subleq_processor_core_tb;
  import spc_pkg::*;

  // opcodes with no meaning, the block answers them with the pc and halted flag alone
  localparam logic [OPCODE_BITS-1:0] OP_NONE_FIRST = 3'd5;
  localparam logic [OPCODE_BITS-1:0] OP_NONE_LAST  = 3'd7;

  localparam int unsigned MEM_WORDS      = 1 << DEFAULT_ADDR_BITS;
  localparam int unsigned REGION_WORDS   = 32;   // programs live in the low words
  localparam int unsigned RUN_BOUND      = 64;   // longest run we let through
  localparam int unsigned PHASE_ITEMS    = 80;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned LONG_STALL     = 400;
  localparam int unsigned FIRST_STALL_AT = 60;
  localparam int unsigned LATER_STALL_AT = 300;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [WORD_BITS-1:0]  read_data;
    logic [FIELD_BITS-1:0] pc;
    logic                  halted;
    logic [STEP_BITS-1:0]  steps;
    logic                  limit_hit;
  } core_result_t;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] op;
    logic [FIELD_BITS-1:0]  addr;
    logic [WORD_BITS-1:0]   data;
    core_result_t           outcome;
  } core_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic [OPCODE_BITS-1:0]    opcode       = '0;
  logic [FIELD_BITS-1:0]     word_address = '0;
  logic [WORD_BITS-1:0]      write_data   = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic [WORD_BITS-1:0]      read_data;
  logic [FIELD_BITS-1:0]     program_counter;
  logic                      halted;
  logic [STEP_BITS-1:0]      steps_done;
  logic                      limit_reached;
  logic                      cfg_write    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

  subleq_processor_core uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .word_address    (word_address),
    .write_data      (write_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .program_counter (program_counter),
    .halted          (halted),
    .steps_done      (steps_done),
    .limit_reached   (limit_reached),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: its own copy of memory, pc and the two registers
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0]  core_mem [MEM_WORDS];
  logic [FIELD_BITS-1:0] core_pc;
  logic [FIELD_BITS-1:0] cfg_start;
  logic [STEP_BITS-1:0]  cfg_limit;

  core_op_t     pending_ops [$];       // generated, not yet taken by the block
  core_result_t awaited_results [$];   // taken, result not yet seen
  int unsigned  failures        = 0;
  int unsigned  results_checked = 0;
  int unsigned  in_gap_max      = 0;
  int unsigned  out_gap_max     = 0;

  // one instruction: mem[b] -= mem[a]; jump to c on a negative or zero result.
  // c comes from the word as fetched, so a write onto itself does not move it
  function automatic void execute_instruction(output logic [FIELD_BITS-1:0] b_addr,
                                              output logic [WORD_BITS-1:0] b_old);
    logic [WORD_BITS-1:0] ins;
    logic [WORD_BITS-1:0] diff;
    ins    = core_mem[core_pc];
    b_addr = ins[31:16];
    b_old  = core_mem[b_addr];
    diff   = b_old - core_mem[ins[47:32]];
    core_mem[b_addr] = diff;
    core_pc = (diff[WORD_BITS-1] || diff == '0) ? ins[15:0] : core_pc + 1'b1;
  endfunction

  // trial run that is rolled back afterwards; tells whether a run would halt soon
  function automatic bit halts_within(int unsigned bound);
    logic [FIELD_BITS-1:0] pc_saved;
    logic [FIELD_BITS-1:0] b_addr;
    logic [WORD_BITS-1:0]  b_old;
    logic [FIELD_BITS-1:0] undo_addr [$];
    logic [WORD_BITS-1:0]  undo_word [$];
    int unsigned           n;
    bit                    stops;
    pc_saved = core_pc;
    n = 0;
    while (n < bound && core_pc != '0) begin
      execute_instruction(b_addr, b_old);
      undo_addr.push_back(b_addr);
      undo_word.push_back(b_old);
      n++;
    end
    stops = (core_pc == '0);
    while (undo_addr.size() > 0)
      core_mem[undo_addr.pop_back()] = undo_word.pop_back();
    core_pc = pc_saved;
    return stops;
  endfunction

  function automatic core_result_t core_outcome(logic [OPCODE_BITS-1:0] op,
                                                logic [FIELD_BITS-1:0] addr,
                                                logic [WORD_BITS-1:0] data);
    core_result_t          r;
    logic [STEP_BITS-1:0]  lim;
    logic [FIELD_BITS-1:0] b_addr;
    logic [WORD_BITS-1:0]  b_old;
    r = '0;
    case (op)
      OP_WRITE: core_mem[addr] = data;
      OP_READ:  r.read_data = core_mem[addr];
      OP_STEP: begin
        if (core_pc != '0) begin
          execute_instruction(b_addr, b_old);
          r.steps = 1;
        end
      end
      OP_RUN: begin
        // a zero limit means the counter's full range
        lim = (cfg_limit == '0) ? STEP_MAX : cfg_limit;
        while (core_pc != '0 && r.steps < lim) begin
          execute_instruction(b_addr, b_old);
          r.steps = r.steps + 1'b1;
        end
        r.limit_hit = (core_pc != '0);
      end
      OP_RESTART: core_pc = cfg_start;
      default: ;
    endcase
    r.pc     = core_pc;
    r.halted = (core_pc == '0);
    return r;
  endfunction

  function automatic void queue_op(logic [OPCODE_BITS-1:0] op,
                                   logic [FIELD_BITS-1:0] addr,
                                   logic [WORD_BITS-1:0] data);
    core_op_t entry;
    entry.op      = op;
    entry.addr    = addr;
    entry.data    = data;
    entry.outcome = core_outcome(op, addr, data);
    pending_ops.push_back(entry);
  endfunction

  function automatic logic [WORD_BITS-1:0] any_word();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [FIELD_BITS-1:0] region_addr();
    return FIELD_BITS'($urandom_range(0, REGION_WORDS - 1));
  endfunction

  // instruction confined to the program region; a jump to zero now and then halts it
  function automatic logic [WORD_BITS-1:0] program_word();
    logic [FIELD_BITS-1:0] c;
    c = ($urandom_range(0, 4) == 0) ? '0 : region_addr();
    return {region_addr(), region_addr(), c};
  endfunction

  // ---------------------------------------------------------------------------
  // input side: acceptance at the rising edge, payload driven at the falling edge
  // ---------------------------------------------------------------------------
  logic        in_took = 1'b0;   // input transaction at the last rising edge
  int unsigned in_gap  = 0;      // idle cycles still to pass before the next offer

  always @(posedge clk) begin
    in_took <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      awaited_results.push_back(pending_ops[0].outcome);
      void'(pending_ops.pop_front());
    end
  end

  always @(negedge clk) begin
    logic offer;
    offer = in_valid && !in_took;   // holding a transaction not yet taken
    if (!rst && !offer) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_ops.size() > 0) begin
        offer        = 1'b1;
        opcode       <= pending_ops[0].op;
        word_address <= pending_ops[0].addr;
        write_data   <= pending_ops[0].data;
        in_gap       = $urandom_range(0, in_gap_max);
      end
    end
    in_valid <= offer;
  end

  // ---------------------------------------------------------------------------
  // output side: ready with random gaps, plus two long hold-offs that back the
  // block up until it refuses input
  // ---------------------------------------------------------------------------
  logic        out_took   = 1'b0;
  int unsigned out_wait   = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    logic rdy;
    rdy = out_ready && !out_took;
    if (out_took && (results_checked == FIRST_STALL_AT || results_checked == LATER_STALL_AT))
      stall_left = LONG_STALL;
    if (!rst && !rdy) begin
      if (stall_left > 0) begin
        stall_left--;
      end else if (out_wait > 0) begin
        out_wait--;
      end else begin
        rdy      = 1'b1;
        out_wait = $urandom_range(0, out_gap_max);
      end
    end
    out_ready <= rdy;
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    core_result_t want;
    out_took <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        $error("result transaction with no input transaction outstanding");
        failures++;
      end else begin
        want = awaited_results.pop_front();
        check_field("read_data", want.read_data, read_data);
        check_field("program_counter", want.pc, program_counter);
        check_field("halted", want.halted, halted);
        check_field("steps_done", want.steps, steps_done);
        check_field("limit_reached", want.limit_hit, limit_reached);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (pending_ops.size() != 0 || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  // register write on the plain port; the predictor follows at once, the block
  // being idle
  task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (index == CFG_START_ADDRESS)
      cfg_start = value[FIELD_BITS-1:0];
    else if (index == CFG_STEP_LIMIT)
      cfg_limit = value;
  endtask

  initial begin
    logic [FIELD_BITS-1:0] far_written [$];
    logic [FIELD_BITS-1:0] far;
    logic [FIELD_BITS-1:0] start_pc;
    logic [STEP_BITS-1:0]  limit;
    int unsigned           pick;

    for (int unsigned i = 0; i < MEM_WORDS; i++)
      core_mem[i] = '0;
    cfg_start = START_ADDRESS_RESET;
    cfg_limit = STEP_LIMIT_RESET;
    core_pc   = START_ADDRESS_RESET;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed, reset settings: start at 1, no step limit
    in_gap_max  = 2;
    out_gap_max = 2;
    queue_op(OP_READ, 16'hFFFF, '0);                 // cleared memory reads zero
    queue_op(OP_WRITE, 16'hFFFF, '1);
    queue_op(OP_READ, 16'hFFFF, '0);
    queue_op(OP_STEP, '0, '0);                       // zero word at pc 1 halts
    queue_op(OP_STEP, '0, '0);                       // step while halted
    queue_op(OP_RUN, '0, '0);                        // run while halted
    queue_op(OP_NONE_LAST, 16'h1234, '1);            // opcode without meaning
    queue_op(OP_WRITE, 16'd16, 48'd1);
    queue_op(OP_WRITE, 16'd17, 48'd3);
    queue_op(OP_WRITE, 16'd1, {16'd16, 16'd17, 16'd0});
    queue_op(OP_WRITE, 16'd2, {16'd18, 16'd18, 16'd1});   // zero result loops back
    queue_op(OP_RESTART, '0, '0);
    queue_op(OP_RUN, '0, '0);                        // countdown loop, five steps
    queue_op(OP_RESTART, '0, '0);
    queue_op(OP_RUN, '0, '0);                        // 0 - 1 wraps negative, jumps
    wait_idle();

    // self-modifying instruction under a limit of one step
    write_register(CFG_START_ADDRESS, 32'd3);
    write_register(CFG_STEP_LIMIT, 32'd1);
    queue_op(OP_WRITE, 16'd3, {16'd5, 16'd3, 16'd9});
    queue_op(OP_WRITE, 16'd5, {16'd5, 16'd3, 16'd9} + 48'd1);
    queue_op(OP_RESTART, '0, '0);
    queue_op(OP_RUN, '0, '0);                        // jumps to the fetched c, limit hit
    queue_op(OP_READ, 16'd3, '0);
    queue_op(OP_RUN, '0, '0);
    wait_idle();

    // pc + 1 wrapping from the top address to zero
    write_register(CFG_START_ADDRESS, {16'hABCD, 16'hFFFF});   // upper bits dropped
    write_register(CFG_STEP_LIMIT, 32'hFFFF_FFFF);
    queue_op(OP_WRITE, 16'd20, 48'd1);
    queue_op(OP_WRITE, 16'd21, 48'd5);
    queue_op(OP_WRITE, 16'hFFFF, {16'd20, 16'd21, 16'd7});
    queue_op(OP_RESTART, '0, '0);
    queue_op(OP_STEP, '0, '0);
    wait_idle();

    // random phases: small programs written, stepped, run and restarted
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      start_pc = FIELD_BITS'($urandom_range(1, REGION_WORDS - 1));
      case (phase)
        0: begin start_pc = '0;       limit = 32'd4;          in_gap_max = 9; out_gap_max = 9; end
        1: begin                      limit = 32'd1;          in_gap_max = 0; out_gap_max = 0; end
        2: begin                      limit = '0;             in_gap_max = 9; out_gap_max = 0; end
        3: begin start_pc = 16'hFFFF; limit = 32'd16;         in_gap_max = 0; out_gap_max = 9; end
        4: begin                      limit = 32'hFFFF_FFFF;  in_gap_max = 9; out_gap_max = 9; end
        default: begin
          limit = $urandom_range(2, RUN_BOUND);
          in_gap_max  = 3;
          out_gap_max = 3;
        end
      endcase
      write_register(CFG_START_ADDRESS, {16'($urandom), start_pc});
      write_register(CFG_STEP_LIMIT, limit);
      queue_op(OP_RESTART, 16'($urandom), any_word());

      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
          queue_op(OP_WRITE, region_addr(),
                   ($urandom_range(0, 3) == 0) ? any_word() : program_word());
        end else if (pick < 33) begin
          far = 16'($urandom);
          far_written.push_back(far);
          queue_op(OP_WRITE, far, any_word());
        end else if (pick < 43) begin
          queue_op(OP_READ, region_addr(), any_word());
        end else if (pick < 48) begin
          far = (far_written.size() > 0 && $urandom_range(0, 1) == 1)
                ? far_written[$urandom_range(0, far_written.size() - 1)] : 16'($urandom);
          queue_op(OP_READ, far, any_word());
        end else if (pick < 68) begin
          queue_op(OP_STEP, 16'($urandom), any_word());
        end else if (pick < 84) begin
          // without a small limit only runs that halt quickly are issued
          if ((cfg_limit != '0 && cfg_limit <= RUN_BOUND) || halts_within(RUN_BOUND))
            queue_op(OP_RUN, 16'($urandom), any_word());
          else
            queue_op(OP_STEP, 16'($urandom), any_word());
        end else if (pick < 97) begin
          queue_op(OP_RESTART, 16'($urandom), any_word());
        end else begin
          queue_op(OPCODE_BITS'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST)),
                   16'($urandom), any_word());
        end
      end
      wait_idle();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // covers the clearing pass after reset and every transaction at its slowest
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
